>>> rtl/tpp_pkg.sv
// ---------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the trapezoidal profile position core.
// ---------------------------------------------------------------------------
package tpp_pkg;

	// field and register widths
	localparam int POS_W         = 32;
	localparam int TIME_W        = 32;
	localparam int REG_W         = 31;
	localparam int CFG_IDX_W     = 1;
	localparam int TPP_FRAC_BITS = 16;

	// square root result width (root of a 64-bit radicand)
	localparam int ROOT_W = 32;

	// product terms saturate at 2^60
	localparam int TERM_W = 61;
	localparam int SUM_W  = 62;
	localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << 60;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = 1'd1;

	// profile phase codes
	typedef enum logic [1:0] {
		PH_ACCEL   = 2'd0,
		PH_CRUISE  = 2'd1,
		PH_DECEL   = 2'd2,
		PH_ARRIVED = 2'd3
	} phase_t;

	// per-word geometry that rides along the pipeline
	typedef struct packed {
		logic signed [POS_W-1:0] start;
		logic signed [POS_W-1:0] goal;
		logic [POS_W-1:0]        dist_abs;
		logic                    fwd;
	} side_t;

endpackage

>>> rtl/tpp_if.sv
// ---------------------------------------------------------------------------
// tpp_if
// Request and response channels of the trapezoidal profile position core.
// ---------------------------------------------------------------------------
interface tpp_req_if;
	import tpp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  start_position;
	logic signed [POS_W-1:0]  goal_position;
	logic [TIME_W-1:0]        elapsed_time;

	modport source(output valid, start_position, goal_position, elapsed_time, input ready);
	modport sink(input valid, start_position, goal_position, elapsed_time, output ready);
endinterface

interface tpp_rsp_if;
	import tpp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  commanded_position;
	logic [1:0]               profile_phase;

	modport source(output valid, commanded_position, profile_phase, input ready);
	modport sink(input valid, commanded_position, profile_phase, output ready);
endinterface

>>> rtl/tpp_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// tpp_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module tpp_sqrt_pipe #(
	parameter int RW = tpp_pkg::ROOT_W
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);
	logic [2*RW-1:0] x_q    [RW];
	logic [RW:0]     rem_q  [RW];
	logic [RW-1:0]   root_q [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [2*RW-1:0] x_in;
		logic [RW:0]     rem_in;
		logic [RW-1:0]   root_in;
		logic [RW+2:0]   cur;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            ge;

		if (i == 0) begin : g_first
			assign x_in    = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign x_in    = x_q[i-1];
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
		end

		// bring down two radicand bits, try root*4+1
		assign cur   = {rem_in, x_in[2*RW-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[i]    <= {x_in[2*RW-3:0], 2'b00};
				rem_q[i]  <= ge ? diff[RW:0] : cur[RW:0];
				root_q[i] <= {root_in[RW-2:0], ge};
			end
		end
	end

	assign root = root_q[RW-1];
endmodule

>>> rtl/tpp_div_pipe.sv
// ---------------------------------------------------------------------------
// tpp_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module tpp_div_pipe #(
	parameter int NW = 48,
	parameter int DW = tpp_pkg::REG_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	// numerator shifts out the top while quotient bits shift in below
	logic [NW-1:0] n_q [NW];
	logic [DW-1:0] r_q [NW];
	logic [DW-1:0] d_q [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [NW-1:0] n_in;
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign n_in = n_q[i-1];
			assign r_in = r_q[i-1];
			assign d_in = d_q[i-1];
		end

		// shift in next numerator bit, subtract divisor if it fits
		assign trial = {r_in, n_in[NW-1]};
		assign ge    = trial >= {1'b0, d_in};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i] <= {n_in[NW-2:0], ge};
				r_q[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				d_q[i] <= d_in;
			end
		end
	end

	assign quo = n_q[NW-1];
endmodule

>>> rtl/trapezoidal_profile_position_core.sv
// ---------------------------------------------------------------------------
// trapezoidal_profile_position_core
// Commanded position and phase on a trapezoidal (or triangular) motion
// profile for a start position, a goal position and an elapsed time.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid/ready      | start_position, goal_position, elapsed_time
//   rsp     | out | valid/ready      | commanded_position, profile_phase
//   cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// One word per cycle is accepted while rsp is not stalled; a word passes through
// the 32-stage square root followed by the (32 + FRAC_BITS) stage dividers
// and 13 arithmetic stages (FRAC_BITS = 16 gives Q15.16 registers).
// Stage s1 and s2 come before the square root, s3..s13 after the dividers.
// arst_n clears the valid bits and loads both registers with 1.0.
// A stall on rsp freezes the whole pipeline; req.ready follows it.
// ---------------------------------------------------------------------------
module trapezoidal_profile_position_core #(
	parameter int FRAC_BITS = tpp_pkg::TPP_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tpp_req_if.sink                        req,
	tpp_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpp_pkg::REG_W-1:0]      cfg_data
);
	import tpp_pkg::*;

	localparam int NW  = POS_W + FRAC_BITS;
	localparam int MID = ROOT_W + NW;
	localparam int LAT = MID + 13;
	localparam int HSH = 2 * FRAC_BITS + 1;
	localparam int PW  = REG_W + 2 * TIME_W;
	localparam int HW  = REG_W + TIME_W;

	logic en;
	logic [LAT-1:0] vld_q;

	logic [REG_W-1:0] max_speed_q, accel_rate_q;
	logic [REG_W-1:0] v_eff, a_eff;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= REG_W'(1) << FRAC_BITS;
			accel_rate_q <= REG_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_SPEED:  max_speed_q  <= cfg_data;
				REG_ACCEL_RATE: accel_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero register reads as one
	assign v_eff = (max_speed_q == '0) ? REG_W'(1) : max_speed_q;
	assign a_eff = (accel_rate_q == '0) ? REG_W'(1) : accel_rate_q;

	// global advance: move unless the output word is stalled
	assign en        = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	// s1: distance and direction
	logic [POS_W:0]    diff;
	side_t             side_s1, side_s2;
	logic [TIME_W-1:0] t_s1, t_s2;
	logic [2*ROOT_W-1:0] rad_s2;

	assign diff = {req.goal_position[POS_W-1], req.goal_position}
		- {req.start_position[POS_W-1], req.start_position};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.start    <= req.start_position;
			side_s1.goal     <= req.goal_position;
			side_s1.fwd      <= !diff[POS_W] && (diff != '0);
			side_s1.dist_abs <= diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
			t_s1             <= req.elapsed_time;
		end
	end

	// s2: radicand distance * accel
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= (2*ROOT_W)'(side_s1.dist_abs) * (2*ROOT_W)'(a_eff);
			side_s2 <= side_s1;
			t_s2    <= t_s1;
		end
	end

	// square root of distance * accel
	logic [ROOT_W-1:0] vp_root;

	tpp_sqrt_pipe #(.RW(ROOT_W)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s2),
		.root (vp_root)
	);

	// side data delay line across square root and dividers
	side_t             side_q [MID];
	logic [TIME_W-1:0] t_q    [MID];
	logic [ROOT_W-1:0] vp_q   [NW];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s2;
			t_q[0]    <= t_s2;
			for (int i = 1; i < MID; i++) begin
				side_q[i] <= side_q[i-1];
				t_q[i]    <= t_q[i-1];
			end
			vp_q[0] <= vp_root;
			for (int i = 1; i < NW; i++) begin
				vp_q[i] <= vp_q[i-1];
			end
		end
	end

	// accel time, distance over speed, triangular accel time
	logic [NW-1:0] ta1_quo, q_quo, ta2_quo;
	side_t         side_root;

	assign side_root = side_q[ROOT_W-1];

	tpp_div_pipe #(.NW(NW), .DW(REG_W)) u_div_ta (
		.clk (clk),
		.en  (en),
		.num ({1'b0, v_eff, {FRAC_BITS{1'b0}}}),
		.den (a_eff),
		.quo (ta1_quo)
	);

	tpp_div_pipe #(.NW(NW), .DW(REG_W)) u_div_q (
		.clk (clk),
		.en  (en),
		.num ({side_root.dist_abs, {FRAC_BITS{1'b0}}}),
		.den (v_eff),
		.quo (q_quo)
	);

	tpp_div_pipe #(.NW(NW), .DW(REG_W)) u_div_tri (
		.clk (clk),
		.en  (en),
		.num ({vp_root, {FRAC_BITS{1'b0}}}),
		.den (a_eff),
		.quo (ta2_quo)
	);

	// s3: pick trapezoid or triangle
	side_t             side_s3;
	logic [TIME_W-1:0] t_s3;
	logic [NW-1:0]     ta_s3, tc_s3;
	logic [ROOT_W-1:0] v_s3;
	logic              trap;

	assign trap = q_quo > ta1_quo;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_q[MID-1];
			t_s3    <= t_q[MID-1];
			tc_s3   <= trap ? q_quo - ta1_quo : '0;
			ta_s3   <= trap ? ta1_quo : ta2_quo;
			v_s3    <= trap ? {1'b0, v_eff} : vp_q[NW-1];
		end
	end

	// s4: phase boundaries
	side_t             side_s4;
	logic [TIME_W-1:0] t_s4;
	logic [NW-1:0]     ta_s4, tc_s4;
	logic [NW:0]       tac_s4;
	logic [NW+1:0]     ttot_s4;
	logic [ROOT_W-1:0] v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			t_s4    <= t_s3;
			ta_s4   <= ta_s3;
			tc_s4   <= tc_s3;
			v_s4    <= v_s3;
			tac_s4  <= (NW+1)'(ta_s3) + (NW+1)'(tc_s3);
			ttot_s4 <= (NW+2)'(tc_s3) + ((NW+2)'(ta_s3) << 1);
		end
	end

	// s5: phase and term operands
	phase_t            ph_c;
	logic [TIME_W-1:0] td, t_ta, xh_c, y1_c, ta32_c;
	logic [NW+1:0]     t_ext;

	assign t_ext = (NW+2)'(t_s4);
	assign td    = t_s4 - tac_s4[TIME_W-1:0];
	assign t_ta  = t_s4 - ta_s4[TIME_W-1:0];

	always_comb begin
		if (t_ext <= (NW+2)'(ta_s4)) begin
			ph_c = PH_ACCEL;
		end else if (tc_s4 != '0 && t_ext <= (NW+2)'(tac_s4)) begin
			ph_c = PH_CRUISE;
		end else if (t_ext <= ttot_s4) begin
			ph_c = PH_DECEL;
		end else begin
			ph_c = PH_ARRIVED;
		end
		xh_c   = (ph_c == PH_ACCEL) ? t_s4 : td;
		y1_c   = (ph_c == PH_CRUISE) ? t_ta : td;
		ta32_c = (ta_s4 > NW'(32'hFFFF_FFFF)) ? '1 : ta_s4[TIME_W-1:0];
	end

	side_t             side_s5;
	phase_t            ph_s5;
	logic [TIME_W-1:0] xh_s5, y1_s5, ta_s5, tc_s5;
	logic [ROOT_W-1:0] v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			ph_s5   <= ph_c;
			xh_s5   <= xh_c;
			y1_s5   <= y1_c;
			ta_s5   <= ta32_c;
			tc_s5   <= tc_s4[TIME_W-1:0];
			v_s5    <= v_s4;
		end
	end

	// s6: squares and speed products
	side_t       side_s6;
	phase_t      ph_s6;
	logic [63:0] hsq_s6, tsq_s6, s1p_s6, s2p_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			ph_s6   <= ph_s5;
			hsq_s6  <= 64'(xh_s5) * 64'(xh_s5);
			tsq_s6  <= 64'(ta_s5) * 64'(ta_s5);
			s1p_s6  <= 64'(v_s5) * 64'(y1_s5);
			s2p_s6  <= 64'(v_s5) * 64'(tc_s5);
		end
	end

	// s7: accel times square, split in halves
	side_t                    side_s7;
	phase_t                   ph_s7;
	logic [REG_W+TIME_W-1:0]  hlo_s7, hhi_s7, tlo_s7, thi_s7;
	logic [TERM_W-1:0]        s1_s7, s2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			ph_s7   <= ph_s6;
			hlo_s7  <= HW'(a_eff) * HW'(hsq_s6[31:0]);
			hhi_s7  <= HW'(a_eff) * HW'(hsq_s6[63:32]);
			tlo_s7  <= HW'(a_eff) * HW'(tsq_s6[31:0]);
			thi_s7  <= HW'(a_eff) * HW'(tsq_s6[63:32]);
			s1_s7   <= TERM_W'(s1p_s6 >> FRAC_BITS);
			s2_s7   <= TERM_W'(s2p_s6 >> FRAC_BITS);
		end
	end

	// s8: join partial products
	side_t             side_s8;
	phase_t            ph_s8;
	logic [PW-1:0]     hprod_s8, tprod_s8;
	logic [TERM_W-1:0] s1_s8, s2_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8  <= side_s7;
			ph_s8    <= ph_s7;
			hprod_s8 <= (PW'(hhi_s7) << 32) + PW'(hlo_s7);
			tprod_s8 <= (PW'(thi_s7) << 32) + PW'(tlo_s7);
			s1_s8    <= s1_s7;
			s2_s8    <= s2_s7;
		end
	end

	// s9: scale and saturate half-accel terms
	logic [PW-1:0] hr, tr;
	side_t             side_s9;
	phase_t            ph_s9;
	logic [TERM_W-1:0] hx_s9, hta_s9, s1_s9, s2_s9;

	assign hr = hprod_s8 >> HSH;
	assign tr = tprod_s8 >> HSH;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9 <= side_s8;
			ph_s9   <= ph_s8;
			hx_s9   <= (hr > PW'(TERM_CAP)) ? TERM_CAP : hr[TERM_W-1:0];
			hta_s9  <= (tr > PW'(TERM_CAP)) ? TERM_CAP : tr[TERM_W-1:0];
			s1_s9   <= s1_s8;
			s2_s9   <= s2_s8;
		end
	end

	// s10: term sums
	side_t            side_s10;
	phase_t           ph_s10;
	logic [SUM_W-1:0] sum_s10, up_s10, dn_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s10 <= side_s9;
			ph_s10   <= ph_s9;
			sum_s10  <= (ph_s9 == PH_CRUISE) ? SUM_W'(s1_s9) + SUM_W'(hta_s9) : SUM_W'(hx_s9);
			up_s10   <= SUM_W'(s2_s9) + SUM_W'(hta_s9) + SUM_W'(s1_s9);
			dn_s10   <= SUM_W'(hx_s9);
		end
	end

	// s11: offset per phase; the decel offset is floored at zero
	logic [SUM_W:0]   ddiff;
	side_t            side_s11;
	phase_t           ph_s11;
	logic [SUM_W-1:0] off_s11;

	assign ddiff = {1'b0, up_s10} - {1'b0, dn_s10};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s11 <= side_s10;
			ph_s11   <= ph_s10;
			if (ph_s10 == PH_DECEL) begin
				off_s11 <= ddiff[SUM_W] ? '0 : ddiff[SUM_W-1:0];
			end else begin
				off_s11 <= sum_s10;
			end
		end
	end

	// s12: clamp offset to distance
	side_t            side_s12;
	phase_t           ph_s12;
	logic [POS_W-1:0] off_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s12 <= side_s11;
			ph_s12   <= ph_s11;
			off_s12  <= (off_s11 > SUM_W'(side_s11.dist_abs)) ? side_s11.dist_abs
				: off_s11[POS_W-1:0];
		end
	end

	// s13: output word; result lies between start and goal so it never wraps
	logic [POS_W:0]          pos_c;
	logic signed [POS_W-1:0] pos_s13;
	phase_t                  ph_s13;

	assign pos_c = side_s12.fwd
		? {side_s12.start[POS_W-1], side_s12.start} + {1'b0, off_s12}
		: {side_s12.start[POS_W-1], side_s12.start} - {1'b0, off_s12};

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s13  <= ph_s12;
			pos_s13 <= (ph_s12 == PH_ARRIVED) ? side_s12.goal : pos_c[POS_W-1:0];
		end
	end

	assign rsp.valid              = vld_q[LAT-1];
	assign rsp.commanded_position = pos_s13;
	assign rsp.profile_phase      = ph_s13;
endmodule

>>> rtl/tpp_checker.sv
// ---------------------------------------------------------------------------
// tpp_checker
// Port-level checks for the trapezoidal profile position core.
// ---------------------------------------------------------------------------
module tpp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic signed [tpp_pkg::POS_W-1:0]    rsp_pos,
	input logic [1:0]                          rsp_phase
);
	import tpp_pkg::*;

	// a stalled output word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	// a stalled output word keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_pos) && $stable(rsp_phase))
		else $error("rsp payload changed while stalled");

	// input stalls only under output back-pressure
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("req ready does not follow output stall");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !rsp_valid)
		else $error("rsp valid right after reset");
endmodule

bind trapezoidal_profile_position_core tpp_checker u_tpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_pos   (rsp.commanded_position),
	.rsp_phase (rsp.profile_phase)
);
